// ===== rtl/rbnp_pkg.sv =====
// Shared types, constants and helpers for the ray box nearest pick block.
package rbnp_pkg;

  localparam int NUM_BOXES_DEF = 64;
  localparam int ID_BITS_DEF   = 16;

  localparam logic       OP_LOAD  = 1'b0;
  localparam logic       OP_QUERY = 1'b1;
  localparam logic [3:0] WS_ID    = 4'd15;
  localparam logic [3:0] WS_MTX0  = 4'd6;
  localparam int         ENABLE_BIT = 16;

  localparam logic signed [31:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0] Q_NEG_ONE = 32'shFFFF_0000;

  typedef struct packed {
    logic               opcode;
    logic [5:0]         box_index;
    logic [3:0]         word_select;
    logic signed [31:0] word_value;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] ray_dir_x;
    logic signed [31:0] ray_dir_y;
    logic signed [31:0] ray_dir_z;
    logic [15:0]        masked_entity;
    logic               mask_enable;
  } in_item_t;

  typedef struct packed {
    logic               hit_found;
    logic [15:0]        hit_entity;
    logic signed [31:0] t_near;
    logic signed [31:0] t_far;
  } out_result_t;

  // clamp a wide signed value to Q16.16 range
  function automatic logic signed [31:0] sat_q(input logic signed [49:0] v);
    logic signed [31:0] res;
    if (v > 50'(Q_MAX)) begin
      res = Q_MAX;
    end else if (v < 50'(Q_MIN)) begin
      res = Q_MIN;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/ray_box_nearest_pick.sv =====
// Top level: box table, sequencer, shared multiplier and bit-serial divider.
// Usage:
//   in_item is taken when start is high and busy is low. A load transaction
//   (opcode 0) writes one word of the box table in that cycle and leaves
//   busy low. A query transaction (opcode 1) raises busy until its single
//   result has been shown.
//   The result appears on out_result for exactly one cycle with out_strobe
//   high; the receiver cannot stall it, so it must take it then.
//   cfg_data (boxes_in_use) is written when cfg_valid and cfg_ready are both
//   high; cfg_ready is low during a query.
// Query sequence: a disabled entry is skipped; a masked entry is skipped once
//   its entity word has been read; any other entry goes through the 3x3
//   rotate on the one 32x32 multiplier and then the restoring divider,
//   49 steps per slab distance and six distances per box. An axis whose
//   rotated direction is zero needs no division; its origin is checked
//   against the slab bounds instead.
// Reset clears the sequencer, the enable bits and boxes_in_use; bounds,
//   matrix and entity words hold whatever they held until loaded.
module ray_box_nearest_pick #(
  parameter int NUM_BOXES = rbnp_pkg::NUM_BOXES_DEF,
  parameter int ID_BITS   = rbnp_pkg::ID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  rbnp_pkg::in_item_t    in_item,
  output logic                  out_strobe,
  output rbnp_pkg::out_result_t out_result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [6:0]            cfg_data
);
  import rbnp_pkg::*;

  localparam int IDX_W = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
  localparam int CNT_W = $clog2(NUM_BOXES + 1);
  localparam int BA_W  = $clog2(NUM_BOXES * 6);
  localparam int MA_W  = $clog2(NUM_BOXES * 9);
  localparam int DIV_STEPS = 49;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BOX  = 4'd1;
  localparam logic [3:0] S_ENT  = 4'd2;
  localparam logic [3:0] S_MRD  = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_BRD  = 4'd6;
  localparam logic [3:0] S_BLO  = 4'd7;
  localparam logic [3:0] S_BHI  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_SLAB = 4'd10;
  localparam logic [3:0] S_EVAL = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  // table storage
  logic signed [31:0] bnd_mem [NUM_BOXES*6];
  logic signed [31:0] mtx_mem [NUM_BOXES*9];
  logic [ID_BITS-1:0] ent_mem [NUM_BOXES];
  logic [NUM_BOXES-1:0] en_r;
  logic signed [31:0] bnd_rd_r, mtx_rd_r;
  logic [ID_BITS-1:0] ent_rd_r;

  logic [3:0]  state_r;
  logic [6:0]  cfg_r;
  logic        strobe_r;
  out_result_t res_r;

  // query context
  logic signed [31:0] org_r [3];
  logic signed [31:0] dir_r [3];
  logic [15:0]        mask_id_r;
  logic               mask_on_r;
  logic [CNT_W-1:0]   cnt_r, b_r;
  logic [1:0]         a_r, c_r;
  logic [3:0]         k_r;
  logic signed [63:0] prod_r;
  logic signed [49:0] acc_r;
  logic signed [31:0] rot_r [3];
  logic signed [31:0] lo_r, hi_r, t0_r, tmin_r, tmax_r;
  logic               side_r;
  logic               found_r;
  logic [ID_BITS-1:0] ent_r, best_ent_r;
  logic signed [31:0] best_n_r, best_f_r;

  // divider
  logic [48:0] n_r;
  logic [31:0] rem_r, dvs_r;
  logic        neg_r;
  logic [5:0]  dcnt_r;

  logic [IDX_W-1:0] b_idx, ld_idx;
  logic             ld_ok, accept;
  logic [BA_W-1:0]  bnd_waddr, bnd_raddr;
  logic [MA_W-1:0]  mtx_waddr, mtx_raddr;
  logic             bnd_re, mtx_re, ent_re;
  logic signed [49:0] acc_nxt;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [32:0] rem_sh;
  logic [33:0] trial;
  logic signed [49:0] q_signed;
  logic signed [31:0] q_sat, t_lo, t_hi, bound_sel;
  logic signed [31:0] mn, mx;
  logic [CNT_W-1:0]   cnt_nxt;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign out_strobe = strobe_r;
  assign out_result = res_r;

  assign b_idx  = IDX_W'(b_r);
  assign ld_idx = IDX_W'(32'(in_item.box_index));
  assign ld_ok  = accept && (in_item.opcode == OP_LOAD) &&
                  (32'(in_item.box_index) < NUM_BOXES);
  assign bnd_waddr = BA_W'(32'(in_item.box_index) * 6 + 32'(in_item.word_select));
  assign mtx_waddr = MA_W'(32'(in_item.box_index) * 9 +
                           32'(in_item.word_select - WS_MTX0));
  assign mtx_raddr = MA_W'(32'(b_r) * 9 + 32'(k_r));
  assign bnd_raddr = (state_r == S_BLO) ? BA_W'(32'(b_r) * 6 + 32'(a_r) + 3)
                                        : BA_W'(32'(b_r) * 6 + 32'(a_r));
  assign bnd_re = (state_r == S_BRD) || (state_r == S_BLO);
  assign mtx_re = (state_r == S_MRD);
  assign ent_re = (state_r == S_BOX);

  always_ff @(posedge clk) begin
    if (ld_ok && in_item.word_select < 4'd6) begin
      bnd_mem[bnd_waddr] <= in_item.word_value;
    end
    if (bnd_re) begin
      bnd_rd_r <= bnd_mem[bnd_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_ok && in_item.word_select >= WS_MTX0 && in_item.word_select < WS_ID) begin
      mtx_mem[mtx_waddr] <= in_item.word_value;
    end
    if (mtx_re) begin
      mtx_rd_r <= mtx_mem[mtx_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_ok && in_item.word_select == WS_ID) begin
      ent_mem[ld_idx] <= ID_BITS'(32'(in_item.word_value));
    end
    if (ent_re) begin
      ent_rd_r <= ent_mem[b_idx];
    end
  end

  // rotate accumulate: floor of the Q32.32 product back to Q16.16
  assign acc_nxt = acc_r + 50'(prod_r >>> 16);

  // slab numerator set-up for the divider
  assign bound_sel = side_r ? hi_r : lo_r;
  assign diff      = 33'(bound_sel) - 33'(org_r[a_r]);
  assign diff_mag  = diff[32] ? 33'(-diff) : diff;

  // one restoring step
  assign rem_sh = {rem_r, n_r[48]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvs_r};

  assign q_signed = neg_r ? -$signed({1'b0, n_r}) : $signed({1'b0, n_r});
  assign q_sat    = sat_q(q_signed);
  assign t_lo     = (t0_r > q_sat) ? q_sat : t0_r;
  assign t_hi     = (t0_r > q_sat) ? t0_r : q_sat;

  // slab limits while the upper bound sits in the read register
  assign mn = (lo_r < bnd_rd_r) ? lo_r : bnd_rd_r;
  assign mx = (lo_r < bnd_rd_r) ? bnd_rd_r : lo_r;

  assign cnt_nxt = (32'(cfg_r) > NUM_BOXES) ? CNT_W'(NUM_BOXES) : CNT_W'(cfg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
      en_r     <= '0;
      cfg_r    <= '0;
    end else begin
      strobe_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
      if (ld_ok && in_item.word_select == WS_ID) begin
        en_r[ld_idx] <= in_item.word_value[ENABLE_BIT];
      end
      case (state_r)
        S_IDLE: begin
          if (accept && in_item.opcode == OP_QUERY) begin
            org_r[0]  <= in_item.origin_x;
            org_r[1]  <= in_item.origin_y;
            org_r[2]  <= in_item.origin_z;
            dir_r[0]  <= in_item.ray_dir_x;
            dir_r[1]  <= in_item.ray_dir_y;
            dir_r[2]  <= in_item.ray_dir_z;
            mask_id_r <= in_item.masked_entity;
            mask_on_r <= in_item.mask_enable;
            cnt_r     <= cnt_nxt;
            b_r       <= '0;
            found_r   <= 1'b0;
            best_n_r  <= Q_MAX;
            best_f_r  <= Q_NEG_ONE;
            best_ent_r <= '0;
            state_r   <= S_BOX;
          end
        end
        S_BOX: begin
          if (b_r == cnt_r) begin
            state_r <= S_DONE;
          end else if (!en_r[b_idx]) begin
            b_r <= b_r + 1'b1;
          end else begin
            state_r <= S_ENT;
          end
        end
        S_ENT: begin
          ent_r <= ent_rd_r;
          if (mask_on_r && 32'(ent_rd_r) == 32'(mask_id_r)) begin
            b_r     <= b_r + 1'b1;
            state_r <= S_BOX;
          end else begin
            a_r     <= '0;
            c_r     <= '0;
            k_r     <= '0;
            acc_r   <= '0;
            tmin_r  <= Q_MIN;
            tmax_r  <= Q_MAX;
            state_r <= S_MRD;
          end
        end
        S_MRD: state_r <= S_MUL;
        S_MUL: begin
          prod_r  <= mtx_rd_r * dir_r[c_r];
          state_r <= S_ACC;
        end
        S_ACC: begin
          k_r <= k_r + 1'b1;
          if (c_r == 2'd2) begin
            rot_r[a_r] <= sat_q(acc_nxt);
            acc_r      <= '0;
            c_r        <= '0;
            if (a_r == 2'd2) begin
              a_r     <= '0;
              state_r <= S_BRD;
            end else begin
              a_r     <= a_r + 1'b1;
              state_r <= S_MRD;
            end
          end else begin
            acc_r   <= acc_nxt;
            c_r     <= c_r + 1'b1;
            state_r <= S_MRD;
          end
        end
        S_BRD: begin
          side_r  <= 1'b0;
          state_r <= S_BLO;
        end
        S_BLO: begin
          lo_r    <= bnd_rd_r;
          state_r <= S_BHI;
        end
        S_BHI: begin
          // bnd_rd_r now holds the upper bound
          hi_r <= bnd_rd_r;
          if (rot_r[a_r] == '0) begin
            if (org_r[a_r] < mn || org_r[a_r] > mx) begin
              b_r     <= b_r + 1'b1;
              state_r <= S_BOX;
            end else if (a_r == 2'd2) begin
              state_r <= S_EVAL;
            end else begin
              a_r     <= a_r + 1'b1;
              state_r <= S_BRD;
            end
          end else begin
            dcnt_r  <= 6'd63;    // S_SLAB sees this as "launch pending"
            state_r <= S_SLAB;
          end
        end
        S_DIV: begin
          if (!trial[33]) begin
            rem_r <= trial[31:0];
          end else begin
            rem_r <= rem_sh[31:0];
          end
          n_r <= {n_r[47:0], !trial[33]};
          if (dcnt_r == '0) begin
            state_r <= S_SLAB;
          end else begin
            dcnt_r <= dcnt_r - 1'b1;
          end
        end
        S_SLAB: begin
          if (dcnt_r == 6'd63) begin
            // divider launch for the current side
            n_r     <= {diff_mag, 16'h0000};
            rem_r   <= '0;
            dvs_r   <= rot_r[a_r][31] ? 32'(-rot_r[a_r]) : 32'(rot_r[a_r]);
            neg_r   <= diff[32] ^ rot_r[a_r][31];
            dcnt_r  <= 6'(DIV_STEPS - 1);
            state_r <= S_DIV;
          end else if (!side_r) begin
            t0_r    <= q_sat;
            side_r  <= 1'b1;
            dcnt_r  <= 6'd63;
          end else begin
            side_r  <= 1'b0;
            dcnt_r  <= 6'd63;
            if (t_lo > tmin_r) tmin_r <= t_lo;
            if (t_hi < tmax_r) tmax_r <= t_hi;
            if (a_r == 2'd2) begin
              state_r <= S_EVAL;
            end else begin
              a_r     <= a_r + 1'b1;
              state_r <= S_BRD;
            end
          end
        end
        S_EVAL: begin
          if (!(tmin_r > tmax_r) && !tmin_r[31] && tmin_r < best_n_r) begin
            found_r    <= 1'b1;
            best_ent_r <= ent_r;
            best_n_r   <= tmin_r;
            best_f_r   <= tmax_r;
          end
          b_r     <= b_r + 1'b1;
          state_r <= S_BOX;
        end
        S_DONE: begin
          strobe_r           <= 1'b1;
          res_r.hit_found    <= found_r;
          res_r.hit_entity   <= found_r ? 16'(32'(best_ent_r)) : 16'h0000;
          res_r.t_near       <= found_r ? best_n_r : Q_NEG_ONE;
          res_r.t_far        <= best_f_r;
          state_r            <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/rbnp_checker.sv =====
// Port-level checker for ray_box_nearest_pick, bound to the top level.
module rbnp_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input rbnp_pkg::in_item_t    in_item,
  input logic                  out_strobe,
  input rbnp_pkg::out_result_t out_result
);
  import rbnp_pkg::*;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe held two cycles");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.opcode == OP_LOAD) |=> !out_strobe)
    else $error("load transaction produced a result");

  a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_result.hit_found) |->
      (out_result.hit_entity == 16'h0000 && out_result.t_near == Q_NEG_ONE &&
       out_result.t_far == Q_NEG_ONE)) else $error("miss result fields wrong");

  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.hit_found) |->
      (!out_result.t_near[31] && out_result.t_near <= out_result.t_far))
    else $error("hit distances out of order");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("busy while showing result");

endmodule

bind ray_box_nearest_pick rbnp_checker u_rbnp_checker (.*);
